>>> src/sia_pkg.sv
package sia_pkg;

   // Fixed field widths of the request and response channels.
   localparam int REQ_TYPE_W  = 3;
   localparam int POSITION_W  = 5;
   localparam int WORD_W      = 32;
   localparam int STATUS_W    = 2;
   localparam int FILL_W      = 5;

   // Default number of storage cells in the chain.
   localparam int DEPTH_DEFAULT = 16;

   // Request codes carried in req_type. The eighth code is unused.
   typedef enum logic [REQ_TYPE_W-1:0] {
      REQ_PUSH_HEAD = 3'd0,
      REQ_PUSH_TAIL = 3'd1,
      REQ_INSERT    = 3'd2,
      REQ_POP_HEAD  = 3'd3,
      REQ_POP_TAIL  = 3'd4,
      REQ_ERASE     = 3'd5,
      REQ_DUMP      = 3'd6
   } req_code_type;

   // Response status codes.
   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

   // Operation broadcast to every cell of the chain.
   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_ERASE,
      CELL_ROTATE
   } cell_op_type;

   // Control group broadcast from the controller to all cells.
   typedef struct packed {
      cell_op_type       op;
      logic [WORD_W-1:0] new_word;
      logic [WORD_W-1:0] head_word;
   } cell_ctrl_type;

   // Controller states.
   typedef enum logic {
      FSM_IDLE,
      FSM_DUMP
   } fsm_state_type;

endpackage

>>> src/sia_req_if.sv
interface sia_req_if;
   logic                                valid;
   logic                                ready;
   logic [sia_pkg::REQ_TYPE_W-1:0]      req_type;
   logic [sia_pkg::POSITION_W-1:0]      position;
   logic signed [sia_pkg::WORD_W-1:0]   word_in;

   modport source (output valid, output req_type, output position, output word_in,
                   input ready);
   modport sink   (input valid, input req_type, input position, input word_in,
                   output ready);
endinterface

>>> src/sia_rsp_if.sv
interface sia_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [sia_pkg::STATUS_W-1:0]        status;
   logic [sia_pkg::FILL_W-1:0]          fill_count;
   logic signed [sia_pkg::WORD_W-1:0]   word_out;
   logic                                last;

   modport source (output valid, output status, output fill_count, output word_out,
                   output last, input ready);
   modport sink   (input valid, input status, input fill_count, input word_out,
                   input last, output ready);
endinterface

>>> src/sia_cell.sv
// One storage cell of the chain. It compares its own index against the
// broadcast mark to decide whether to hold, load, or take a neighbor's word.
module sia_cell #(
   parameter int IW    = 5,
   parameter int INDEX = 0
) (
   input  logic                           clock,
   input  sia_pkg::cell_ctrl_type         ctrl,
   input  logic [IW-1:0]                  mark,
   input  logic [sia_pkg::WORD_W-1:0]     left_word,
   input  logic [sia_pkg::WORD_W-1:0]     right_word,
   output logic [sia_pkg::WORD_W-1:0]     word
);

   localparam logic [IW-1:0] MY_INDEX = IW'(INDEX);

   logic [sia_pkg::WORD_W-1:0] word_ff;
   logic [sia_pkg::WORD_W-1:0] word_in;

   always_comb begin
      word_in = word_ff;
      unique case (ctrl.op)
         sia_pkg::CELL_HOLD: begin
            word_in = word_ff;
         end
         sia_pkg::CELL_INSERT: begin
            if (MY_INDEX == mark) begin
               word_in = ctrl.new_word;
            end else if (MY_INDEX > mark) begin
               word_in = left_word;
            end
         end
         sia_pkg::CELL_ERASE: begin
            if (MY_INDEX >= mark) begin
               word_in = right_word;
            end
         end
         sia_pkg::CELL_ROTATE: begin
            if (MY_INDEX == mark) begin
               word_in = ctrl.head_word;
            end else if (MY_INDEX < mark) begin
               word_in = right_word;
            end
         end
         default: begin
            word_in = word_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word = word_ff;

endmodule

>>> src/shift_insert_array.sv
// Channel  | Direction | Payload                                  | Transfer when
// ---------+-----------+------------------------------------------+--------------------
// req_ch   | in        | req_type, position, word_in              | valid && ready
// rsp_ch   | out       | status, fill_count, word_out, last       | valid && ready
//
// Requests other than dump give a single response: a successful edit moves the cells in
// the transfer cycle and the response is registered. A dump of N words gives N responses,
// one per word, out of cell 0, as the chain rotates one place per word back to its order.
// Reset (synchronous, active high) clears the fill count and the controller, not the cells.
// A stalled response holds its register and freezes the chain; no request is taken while
// a dump is in progress.
module shift_insert_array #(
   parameter int DEPTH = sia_pkg::DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   sia_req_if.sink    req_ch,
   sia_rsp_if.source  rsp_ch
);

   // Count width holds 0..DEPTH; indexes into the chain use the same width.
   localparam int CW = $clog2(DEPTH + 1);
   // Comparison width that covers both the count and the request position.
   localparam int PW = (CW > sia_pkg::POSITION_W) ? CW : sia_pkg::POSITION_W;

   logic [sia_pkg::WORD_W-1:0] cell_word [DEPTH];

   sia_pkg::cell_ctrl_type     cell_ctrl;
   logic [CW-1:0]              cell_mark;

   sia_pkg::fsm_state_type     fsm_ff;
   sia_pkg::fsm_state_type     fsm_in;
   logic [CW-1:0]              count_ff;
   logic [CW-1:0]              count_in;
   logic [CW-1:0]              dump_idx_ff;
   logic [CW-1:0]              dump_idx_in;

   logic                       rsp_valid_ff;
   logic                       rsp_valid_in;
   logic [sia_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [sia_pkg::STATUS_W-1:0] rsp_status_in;
   logic [sia_pkg::FILL_W-1:0] rsp_fill_ff;
   logic [sia_pkg::FILL_W-1:0] rsp_fill_in;
   logic [sia_pkg::WORD_W-1:0] rsp_word_ff;
   logic [sia_pkg::WORD_W-1:0] rsp_word_in;
   logic                       rsp_last_ff;
   logic                       rsp_last_in;

   logic                       out_free;
   logic                       accept;
   logic                       is_full;
   logic                       is_empty;
   logic [PW-1:0]              edit_pos;
   logic [PW-1:0]              count_ext;
   logic                       emit;
   logic                       start_dump;
   logic                       dump_done;

   // ------------------------------------------------------------------
   // Chain of cells. Each cell sees its two neighbors; the ends see zero.
   // ------------------------------------------------------------------
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic [sia_pkg::WORD_W-1:0] left_word;
      logic [sia_pkg::WORD_W-1:0] right_word;

      if (g == 0) begin : g_left_end
         assign left_word = '0;
      end else begin : g_left
         assign left_word = cell_word[g-1];
      end

      if (g == DEPTH - 1) begin : g_right_end
         assign right_word = '0;
      end else begin : g_right
         assign right_word = cell_word[g+1];
      end

      sia_cell #(
         .IW    (CW),
         .INDEX (g)
      ) u_cell (
         .clock      (clock),
         .ctrl       (cell_ctrl),
         .mark       (cell_mark),
         .left_word  (left_word),
         .right_word (right_word),
         .word       (cell_word[g])
      );
   end

   // ------------------------------------------------------------------
   // Handshake. The response register frees up when it is empty or when
   // its current word is being taken in this cycle.
   // ------------------------------------------------------------------
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = (fsm_ff == sia_pkg::FSM_IDLE) && out_free;
   assign accept       = req_ch.valid && req_ch.ready;

   assign is_full   = (count_ff == CW'(DEPTH));
   assign is_empty  = (count_ff == '0);
   assign count_ext = PW'(count_ff);

   // Position that an edit works on. Pop tail uses count - 1, which is only
   // acted upon when the array is not empty.
   always_comb begin
      unique case (req_ch.req_type)
         sia_pkg::REQ_PUSH_HEAD: edit_pos = '0;
         sia_pkg::REQ_PUSH_TAIL: edit_pos = count_ext;
         sia_pkg::REQ_POP_HEAD:  edit_pos = '0;
         sia_pkg::REQ_POP_TAIL:  edit_pos = count_ext - PW'(1);
         default:                edit_pos = PW'(req_ch.position);
      endcase
   end

   // ------------------------------------------------------------------
   // Controller outputs: cell operation, count update and the response.
   // ------------------------------------------------------------------
   always_comb begin
      cell_ctrl.op        = sia_pkg::CELL_HOLD;
      cell_ctrl.new_word  = req_ch.word_in;
      cell_ctrl.head_word = cell_word[0];
      cell_mark           = edit_pos[CW-1:0];
      count_in            = count_ff;
      dump_idx_in         = dump_idx_ff;
      emit                = 1'b0;
      start_dump          = 1'b0;
      dump_done           = 1'b0;
      rsp_status_in       = sia_pkg::ST_OK;
      rsp_word_in         = '0;
      rsp_last_in         = 1'b1;

      if (accept) begin
         emit = 1'b1;
         unique case (req_ch.req_type)
            sia_pkg::REQ_PUSH_HEAD, sia_pkg::REQ_PUSH_TAIL, sia_pkg::REQ_INSERT: begin
               // Fullness is checked before the position.
               if (is_full) begin
                  rsp_status_in = sia_pkg::ST_FULL;
               end else if (edit_pos > count_ext) begin
                  rsp_status_in = sia_pkg::ST_RANGE;
               end else begin
                  cell_ctrl.op = sia_pkg::CELL_INSERT;
                  count_in     = count_ff + CW'(1);
               end
            end
            sia_pkg::REQ_POP_HEAD, sia_pkg::REQ_POP_TAIL, sia_pkg::REQ_ERASE: begin
               // Emptiness is checked before the position.
               if (is_empty) begin
                  rsp_status_in = sia_pkg::ST_EMPTY;
               end else if (edit_pos >= count_ext) begin
                  rsp_status_in = sia_pkg::ST_RANGE;
               end else begin
                  cell_ctrl.op = sia_pkg::CELL_ERASE;
                  count_in     = count_ff - CW'(1);
               end
            end
            sia_pkg::REQ_DUMP: begin
               // An empty dump gives a single zero word marked last. Otherwise
               // the head word goes out now and the chain rotates by one.
               if (!is_empty) begin
                  cell_ctrl.op = sia_pkg::CELL_ROTATE;
                  cell_mark    = count_ff - CW'(1);
                  rsp_word_in  = cell_word[0];
                  rsp_last_in  = (count_ff == CW'(1));
                  start_dump   = (count_ff != CW'(1));
                  dump_idx_in  = CW'(1);
               end
            end
            default: begin
               // The unused request code only reports the current state.
            end
         endcase
      end else if (fsm_ff == sia_pkg::FSM_DUMP && out_free) begin
         emit         = 1'b1;
         cell_ctrl.op = sia_pkg::CELL_ROTATE;
         cell_mark    = count_ff - CW'(1);
         rsp_word_in  = cell_word[0];
         rsp_last_in  = (dump_idx_ff == count_ff - CW'(1));
         dump_done    = rsp_last_in;
         dump_idx_in  = dump_idx_ff + CW'(1);
      end
   end

   // Fill count is reported modulo the width of the response field.
   assign rsp_fill_in  = sia_pkg::FILL_W'(count_in);
   assign rsp_valid_in = emit || (rsp_valid_ff && !rsp_ch.ready);

   // ------------------------------------------------------------------
   // Controller next state.
   // ------------------------------------------------------------------
   always_comb begin
      fsm_in = fsm_ff;
      unique case (fsm_ff)
         sia_pkg::FSM_IDLE: begin
            if (start_dump) begin
               fsm_in = sia_pkg::FSM_DUMP;
            end
         end
         sia_pkg::FSM_DUMP: begin
            if (dump_done) begin
               fsm_in = sia_pkg::FSM_IDLE;
            end
         end
         default: begin
            fsm_in = sia_pkg::FSM_IDLE;
         end
      endcase
   end

   // ------------------------------------------------------------------
   // Registers.
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff       <= sia_pkg::FSM_IDLE;
         count_ff     <= '0;
         dump_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fsm_ff       <= fsm_in;
         count_ff     <= count_in;
         dump_idx_ff  <= dump_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_status_ff <= rsp_status_in;
         rsp_fill_ff   <= rsp_fill_in;
         rsp_word_ff   <= rsp_word_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.status     = rsp_status_ff;
   assign rsp_ch.fill_count = rsp_fill_ff;
   assign rsp_ch.word_out   = rsp_word_ff;
   assign rsp_ch.last       = rsp_last_ff;

   // ------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("fill count exceeds the number of cells");

   a_no_req_in_dump: assert property (@(posedge clock) disable iff (reset)
      fsm_ff == sia_pkg::FSM_DUMP |-> !req_ch.ready)
      else $error("request taken while a dump is in progress");

   a_dump_idx_range: assert property (@(posedge clock) disable iff (reset)
      fsm_ff == sia_pkg::FSM_DUMP |-> (dump_idx_ff != '0) && (dump_idx_ff < count_ff))
      else $error("dump index outside the stored entries");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff == sia_pkg::ST_FULL |-> count_ff == CW'(DEPTH))
      else $error("full status reported while space remains");

   a_count_stable_dump: assert property (@(posedge clock) disable iff (reset)
      fsm_ff == sia_pkg::FSM_DUMP |=> count_ff == $past(count_ff))
      else $error("fill count changed during a dump");

endmodule

>>> test/tb_top.sv
module tb_top;

   // The array holds at most this many words; the block uses its default size.
   localparam int CAP = sia_pkg::DEPTH_DEFAULT;

   // The eighth request code has no operation behind it. The block still
   // answers it with a single response that reports the current fill count.
   localparam logic [sia_pkg::REQ_TYPE_W-1:0] REQ_UNUSED = 3'd7;

   // Random part of the stimulus. The last stretch runs with no idle cycles on
   // either side, and the sender drains the block once in the middle.
   localparam int RAND_ITEMS   = 410;
   localparam int QUIET_ITEMS  = 60;
   localparam int DRAIN_AT     = 250;
   localparam int PHASE_ITEMS  = 40;

   // The receiver holds ready low for this many cycles once it has seen
   // enough transfers, so that the response register fills and the block
   // stops taking requests while the sender keeps offering them.
   localparam int HOLD_AFTER   = 120;
   localparam int HOLD_CYCLES  = 80;

   // One response as it appears on the result channel.
   typedef struct {
      sia_pkg::status_type                status;
      logic [sia_pkg::FILL_W-1:0]         fill;
      logic signed [sia_pkg::WORD_W-1:0]  word;
      logic                               last;
   } array_reply_type;

   // One row of the directed stimulus. A row may repeat its request, with a
   // fresh random word each time when rnd_word is set. Where typed is set,
   // the single response of the request is written into the row; otherwise
   // the responses come from the mirror of the array below.
   typedef struct {
      logic [sia_pkg::REQ_TYPE_W-1:0]     code;
      logic [sia_pkg::POSITION_W-1:0]     pos;
      logic [sia_pkg::WORD_W-1:0]         word;
      int                                 reps;
      bit                                 rnd_word;
      bit                                 typed;
      sia_pkg::status_type                st;
      logic [sia_pkg::FILL_W-1:0]         fill;
   } stim_row_type;

   localparam int DIR_ROWS = 25;

   // The directed sequence first probes every rejection on the empty array,
   // then builds a short array with the word extremes at known places, then
   // fills it up to probe the full cases, including the rule that fullness
   // and emptiness win over a bad position.
   stim_row_type dir_rows [DIR_ROWS] = '{
      '{sia_pkg::REQ_DUMP,      5'd0,  32'h0000_0000, 1,  1'b0, 1'b1, sia_pkg::ST_OK,    5'd0},
      '{sia_pkg::REQ_POP_HEAD,  5'd0,  32'h0000_0000, 1,  1'b0, 1'b1, sia_pkg::ST_EMPTY, 5'd0},
      '{sia_pkg::REQ_POP_TAIL,  5'd0,  32'h0000_0000, 1,  1'b0, 1'b1, sia_pkg::ST_EMPTY, 5'd0},
      '{sia_pkg::REQ_ERASE,     5'd0,  32'h0000_0000, 1,  1'b0, 1'b1, sia_pkg::ST_EMPTY, 5'd0},
      '{sia_pkg::REQ_ERASE,     5'd31, 32'h0000_0000, 1,  1'b0, 1'b1, sia_pkg::ST_EMPTY, 5'd0},
      '{sia_pkg::REQ_INSERT,    5'd1,  32'h1234_5678, 1,  1'b0, 1'b1, sia_pkg::ST_RANGE, 5'd0},
      '{REQ_UNUSED,             5'd0,  32'h0000_0000, 1,  1'b0, 1'b1, sia_pkg::ST_OK,    5'd0},
      '{sia_pkg::REQ_PUSH_TAIL, 5'd0,  32'h7fff_ffff, 1,  1'b0, 1'b1, sia_pkg::ST_OK,    5'd1},
      '{sia_pkg::REQ_PUSH_HEAD, 5'd0,  32'h8000_0000, 1,  1'b0, 1'b1, sia_pkg::ST_OK,    5'd2},
      '{sia_pkg::REQ_INSERT,    5'd1,  32'hffff_ffff, 1,  1'b0, 1'b1, sia_pkg::ST_OK,    5'd3},
      '{sia_pkg::REQ_INSERT,    5'd3,  32'h0000_0000, 1,  1'b0, 1'b1, sia_pkg::ST_OK,    5'd4},
      '{sia_pkg::REQ_INSERT,    5'd5,  32'h5555_aaaa, 1,  1'b0, 1'b1, sia_pkg::ST_RANGE, 5'd4},
      '{sia_pkg::REQ_ERASE,     5'd4,  32'h0000_0000, 1,  1'b0, 1'b1, sia_pkg::ST_RANGE, 5'd4},
      '{sia_pkg::REQ_DUMP,      5'd0,  32'h0000_0000, 1,  1'b0, 1'b0, sia_pkg::ST_OK,    5'd0},
      '{sia_pkg::REQ_ERASE,     5'd1,  32'h0000_0000, 1,  1'b0, 1'b1, sia_pkg::ST_OK,    5'd3},
      '{sia_pkg::REQ_POP_HEAD,  5'd0,  32'h0000_0000, 1,  1'b0, 1'b1, sia_pkg::ST_OK,    5'd2},
      '{sia_pkg::REQ_POP_TAIL,  5'd0,  32'h0000_0000, 1,  1'b0, 1'b1, sia_pkg::ST_OK,    5'd1},
      '{sia_pkg::REQ_PUSH_TAIL, 5'd0,  32'h0000_0000, 15, 1'b1, 1'b0, sia_pkg::ST_OK,    5'd0},
      '{sia_pkg::REQ_PUSH_HEAD, 5'd0,  32'h0bad_f00d, 1,  1'b0, 1'b1, sia_pkg::ST_FULL,  5'd16},
      '{sia_pkg::REQ_PUSH_TAIL, 5'd0,  32'h0bad_f00d, 1,  1'b0, 1'b1, sia_pkg::ST_FULL,  5'd16},
      '{sia_pkg::REQ_INSERT,    5'd31, 32'h0bad_f00d, 1,  1'b0, 1'b1, sia_pkg::ST_FULL,  5'd16},
      '{sia_pkg::REQ_ERASE,     5'd16, 32'h0000_0000, 1,  1'b0, 1'b1, sia_pkg::ST_RANGE, 5'd16},
      '{REQ_UNUSED,             5'd9,  32'hffff_ffff, 1,  1'b0, 1'b1, sia_pkg::ST_OK,    5'd16},
      '{sia_pkg::REQ_DUMP,      5'd0,  32'h0000_0000, 1,  1'b0, 1'b0, sia_pkg::ST_OK,    5'd0},
      '{sia_pkg::REQ_ERASE,     5'd15, 32'h0000_0000, 1,  1'b0, 1'b1, sia_pkg::ST_OK,    5'd15}
   };

   logic clock;
   logic reset;

   sia_req_if req_ch ();
   sia_rsp_if rsp_ch ();

   shift_insert_array uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // Mirror of the array contents. Only entries below mirror_count are ever
   // read, so the unwritten upper entries never matter.
   logic signed [sia_pkg::WORD_W-1:0] mirror_words [CAP];
   int                                mirror_count;

   // Responses computed for the request just accepted, and the responses
   // still owed by the block, oldest first.
   array_reply_type new_replies [$];
   array_reply_type replies_due [$];

   int mismatches;
   bit idle_on;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // The slowest correct run is far below this: even if every request were a
   // full dump with each response waiting out the longest short receiver stall,
   // the whole run stays under a fifth of it.
   initial begin
      #3000000;
      $display("tb_top NOT OK");
      $finish;
   end

   // Insert a word at a position, shifting the later words up by one place.
   // Fullness is checked before the position, so a full array reports full
   // even for a position far past the end.
   function automatic sia_pkg::status_type mirror_insert(int at,
                                                         logic signed [sia_pkg::WORD_W-1:0] w);
      if (mirror_count >= CAP)
         return sia_pkg::ST_FULL;
      if (at > mirror_count)
         return sia_pkg::ST_RANGE;
      for (int i = mirror_count; i > at; i--)
         mirror_words[i] = mirror_words[i-1];
      mirror_words[at] = w;
      mirror_count++;
      return sia_pkg::ST_OK;
   endfunction

   // Remove the word at a position, shifting the later words down. An empty
   // array reports empty before the position is looked at, which also covers
   // a tail pop on an empty array.
   function automatic sia_pkg::status_type mirror_erase(int at);
      if (mirror_count == 0)
         return sia_pkg::ST_EMPTY;
      if (at >= mirror_count)
         return sia_pkg::ST_RANGE;
      for (int i = at; i + 1 < mirror_count; i++)
         mirror_words[i] = mirror_words[i+1];
      mirror_count--;
      return sia_pkg::ST_OK;
   endfunction

   // Apply one request to the mirror and list the responses it causes.
   // A dump gives one response per stored word, in order, with last on the
   // final one; a dump of an empty array gives a single response with a zero
   // word. Every other request gives one response with a zero word.
   task automatic compute_replies(input logic [sia_pkg::REQ_TYPE_W-1:0] code,
                                  input logic [sia_pkg::POSITION_W-1:0] pos,
                                  input logic signed [sia_pkg::WORD_W-1:0] w);
      sia_pkg::status_type st;
      st = sia_pkg::ST_OK;
      new_replies.delete();
      case (code)
         sia_pkg::REQ_PUSH_HEAD: st = mirror_insert(0, w);
         sia_pkg::REQ_PUSH_TAIL: st = mirror_insert(mirror_count, w);
         sia_pkg::REQ_INSERT:    st = mirror_insert(int'(pos), w);
         sia_pkg::REQ_POP_HEAD:  st = mirror_erase(0);
         sia_pkg::REQ_POP_TAIL:  st = mirror_erase(mirror_count - 1);
         sia_pkg::REQ_ERASE:     st = mirror_erase(int'(pos));
         sia_pkg::REQ_DUMP: begin
            for (int i = 0; i < mirror_count; i++)
               new_replies.push_back('{sia_pkg::ST_OK, sia_pkg::FILL_W'(mirror_count),
                                      mirror_words[i], (i + 1 == mirror_count)});
         end
         default: st = sia_pkg::ST_OK;
      endcase
      if (new_replies.size() == 0)
         new_replies.push_back('{st, sia_pkg::FILL_W'(mirror_count), '0, 1'b1});
   endtask

   // Offer one request and keep it on the channel until it transfers, then
   // record what the block owes for it. The valid line is only lowered for a
   // gap, so back-to-back requests keep it high without a glitch.
   task automatic offer_request(input logic [sia_pkg::REQ_TYPE_W-1:0] code,
                                input logic [sia_pkg::POSITION_W-1:0] pos,
                                input logic signed [sia_pkg::WORD_W-1:0] w,
                                input bit typed,
                                input sia_pkg::status_type st,
                                input logic [sia_pkg::FILL_W-1:0] fill);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.req_type <= code;
      req_ch.position <= pos;
      req_ch.word_in  <= w;
      do
         @(posedge clock);
      while (!req_ch.ready);
      compute_replies(code, pos, w);
      if (typed)
         replies_due.push_back('{st, fill, '0, 1'b1});
      else
         foreach (new_replies[i])
            replies_due.push_back(new_replies[i]);
   endtask

   // Words at the signed extremes and around zero turn up now and then;
   // the rest are uniformly random.
   function automatic logic signed [sia_pkg::WORD_W-1:0] pick_word();
      if ($urandom_range(0, 9) != 0)
         return $urandom;
      case ($urandom_range(0, 3))
         0:       return 32'sh8000_0000;
         1:       return 32'sh7fff_ffff;
         2:       return 32'sh0000_0000;
         default: return 32'shffff_ffff;
      endcase
   endfunction

   // Sender: reset, the directed rows, then random requests. The random part
   // alternates between filling and draining stretches so that the full and
   // empty cases keep coming up, and positions are mostly inside the valid
   // range with some anywhere in the five-bit field.
   initial begin
      logic [sia_pkg::REQ_TYPE_W-1:0]    code;
      logic [sia_pkg::POSITION_W-1:0]    pos;
      logic signed [sia_pkg::WORD_W-1:0] w;
      int                                push_pct;
      int                                roll;

      reset           <= 1'b1;
      req_ch.valid    <= 1'b0;
      req_ch.req_type <= sia_pkg::REQ_DUMP;
      req_ch.position <= '0;
      req_ch.word_in  <= '0;
      idle_on         <= 1'b1;
      mirror_count     = 0;
      mismatches       = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[r]) begin
         for (int k = 0; k < dir_rows[r].reps; k++) begin
            w = dir_rows[r].rnd_word ? pick_word() : dir_rows[r].word;
            offer_request(dir_rows[r].code, dir_rows[r].pos, w, dir_rows[r].typed,
                          dir_rows[r].st, dir_rows[r].fill);
         end
      end

      for (int n = 0; n < RAND_ITEMS; n++) begin
         if (n == RAND_ITEMS - QUIET_ITEMS)
            idle_on <= 1'b0;

         // Let the block run dry once before going on.
         if (n == DRAIN_AT) begin
            req_ch.valid <= 1'b0;
            do
               @(negedge clock);
            while (replies_due.size() != 0);
            @(posedge clock);
         end

         push_pct = ((n / PHASE_ITEMS) % 2 == 0) ? 75 : 25;
         roll     = $urandom_range(0, 99);
         if (roll < push_pct) begin
            case ($urandom_range(0, 2))
               0:       code = sia_pkg::REQ_PUSH_HEAD;
               1:       code = sia_pkg::REQ_PUSH_TAIL;
               default: code = sia_pkg::REQ_INSERT;
            endcase
         end else if (roll < 92) begin
            case ($urandom_range(0, 2))
               0:       code = sia_pkg::REQ_POP_HEAD;
               1:       code = sia_pkg::REQ_POP_TAIL;
               default: code = sia_pkg::REQ_ERASE;
            endcase
         end else if (roll < 98) begin
            code = sia_pkg::REQ_DUMP;
         end else begin
            code = REQ_UNUSED;
         end

         if ($urandom_range(0, 6) == 0)
            pos = sia_pkg::POSITION_W'($urandom_range(0, 31));
         else if (code == sia_pkg::REQ_INSERT)
            pos = sia_pkg::POSITION_W'($urandom_range(0, mirror_count));
         else if (code == sia_pkg::REQ_ERASE)
            pos = sia_pkg::POSITION_W'($urandom_range(0,
                     (mirror_count > 0) ? mirror_count - 1 : 0));
         else
            pos = sia_pkg::POSITION_W'($urandom_range(0, 31));

         offer_request(code, pos, pick_word(), 1'b0, sia_pkg::ST_OK, '0);
      end
      req_ch.valid <= 1'b0;

      // Wait for every owed response, then a little longer in case the block
      // sends something it should not.
      do
         @(negedge clock);
      while (replies_due.size() != 0);
      repeat (20) @(posedge clock);

      if (mismatches == 0 && replies_due.size() == 0)
         $display("tb_top OK");
      else
         $display("tb_top NOT OK");
      $finish;
   end

   // Receiver: short random stalls while idling is on, and one long hold-off
   // once enough transfers have gone by. It counts transfers itself so that
   // its timing does not depend on the checker below.
   initial begin
      int  seen;
      bit  held;
      seen = 0;
      held = 1'b0;
      rsp_ch.ready <= 1'b1;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready)
            seen++;
         if (!held && seen >= HOLD_AFTER) begin
            held = 1'b1;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_ch.ready <= 1'b1;
         end else if (idle_on && $urandom_range(0, 6) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Checker: every response transfer is matched against the oldest owed
   // response, field by field. A response with nothing owed is a failure.
   always @(posedge clock) begin
      array_reply_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (replies_due.size() == 0) begin
            $error("unexpected response: status %0d fill_count %0d word_out %0d last %0b",
                   rsp_ch.status, rsp_ch.fill_count, rsp_ch.word_out, rsp_ch.last);
            mismatches++;
         end else begin
            want = replies_due.pop_front();
            if (rsp_ch.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
               mismatches++;
            end
            if (rsp_ch.fill_count !== want.fill) begin
               $error("fill_count: expected %0d, got %0d", want.fill, rsp_ch.fill_count);
               mismatches++;
            end
            if (rsp_ch.word_out !== want.word) begin
               $error("word_out: expected %0d, got %0d", want.word, rsp_ch.word_out);
               mismatches++;
            end
            if (rsp_ch.last !== want.last) begin
               $error("last: expected %0b, got %0b", want.last, rsp_ch.last);
               mismatches++;
            end
         end
      end
   end

endmodule

>>> filelist.f
src/sia_pkg.sv
src/sia_req_if.sv
src/sia_rsp_if.sv
src/sia_cell.sv
src/shift_insert_array.sv
test/tb_top.sv
